@@ rtl/pcbp_pkg.sv @@
`timescale 1ns / 1ps

package pcbp_pkg;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;
    localparam int SYM_W      = 8;
    localparam int CODE_W     = 32;
    localparam int LEN_W      = 6;
    localparam int PEND_W     = 7;
    localparam int PCNT_W     = 3;
    localparam int TABLE_DEPTH = 256;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_ERROR = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;

    typedef struct packed {
        logic accept;
        logic load;
        logic build;
        logic emit_byte;
        logic commit;
        logic emit_err;
        logic emit_flush;
    } pcbp_cmd_t;

    typedef struct packed {
        logic unmapped;
        logic has_byte;
        logic slot_free;
    } pcbp_stat_t;

endpackage

@@ rtl/pcbp_ram.sv @@
`timescale 1ns / 1ps

module pcbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pcbp_ctrl.sv @@
`timescale 1ns / 1ps

module pcbp_ctrl
    import pcbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] opcode,
    input  pcbp_stat_t stat,
    output logic       in_ready,
    output pcbp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_EMIT,
        S_ERR,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    case (opcode)
                        OP_LOAD:   cmd.load   = 1'b1;
                        OP_ENCODE: state_next = S_LOOKUP;
                        OP_FLUSH:  state_next = S_FLUSH;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP:
            begin
                if (stat.unmapped)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    cmd.build  = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!stat.has_byte)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.slot_free)
                begin
                    cmd.emit_byte = 1'b1;
                end
            end
            S_ERR:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit_flush = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/pcbp_datapath.sv @@
`timescale 1ns / 1ps

module pcbp_datapath
    import pcbp_pkg::*;
#(
    parameter int LEN_LIMIT = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pcbp_cmd_t         cmd,
    input  logic [SYM_W-1:0]  symbol,
    input  logic [CODE_W-1:0] code_bits,
    input  logic [LEN_W-1:0]  code_length,
    input  logic              out_ready,
    output pcbp_stat_t        stat,
    output logic              out_valid,
    output logic [7:0]        out_byte,
    output logic [1:0]        out_status,
    output logic              out_last
);

    localparam int ENT_W  = LEN_LIMIT + LEN_W;
    localparam int WIN_W  = LEN_LIMIT + 8;
    localparam int CNT_W  = $clog2(WIN_W);
    localparam logic [LEN_W-1:0] LIM = LEN_W'(LEN_LIMIT);

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   ent_valid_reg;
    logic [ENT_W-1:0]       ent_rd;
    logic [LEN_W-1:0]       len_wr;
    logic [LEN_W-1:0]       len_rd;
    logic [LEN_W-1:0]       shamt;
    logic [LEN_LIMIT-1:0]   code_al;
    logic [WIN_W-1:0]       code_ext;
    logic [WIN_W-1:0]       win_build;
    logic [6:0]             total;

    logic [WIN_W-1:0]  win_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PEND_W-1:0] pend_reg;
    logic [PCNT_W-1:0] pcnt_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic [1:0]        out_status_reg;
    logic              out_last_reg;

    assign len_wr = (code_length > LIM) ? LIM : code_length;

    pcbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.load),
        .addr  (symbol),
        .wdata ({len_wr, code_bits[LEN_LIMIT-1:0]}),
        .rdata (ent_rd)
    );

    assign len_rd    = ent_rd[LEN_LIMIT +: LEN_W];
    assign shamt     = LIM - len_rd;
    assign code_al   = ent_rd[LEN_LIMIT-1:0] << shamt;
    assign code_ext  = {code_al, 8'b0};
    assign win_build = {pend_reg, {(LEN_LIMIT + 1){1'b0}}} | (code_ext >> pcnt_reg);
    assign total     = 7'(pcnt_reg) + 7'(len_rd);

    assign stat.unmapped  = !ent_valid_reg || (len_rd == '0);
    assign stat.has_byte  = (cnt_reg >> 3) != '0;
    assign stat.slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            ent_valid_reg <= 1'b0;
            pend_reg      <= '0;
            pcnt_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                valid_reg[symbol] <= 1'b1;
            end
            if (cmd.accept)
            begin
                ent_valid_reg <= valid_reg[symbol];
            end
            if (cmd.build)
            begin
                cnt_reg <= total[CNT_W-1:0];
            end
            else if (cmd.emit_byte)
            begin
                cnt_reg <= cnt_reg - CNT_W'(8);
            end
            if (cmd.commit)
            begin
                pend_reg <= win_reg[WIN_W-1 -: PEND_W];
                pcnt_reg <= cnt_reg[PCNT_W-1:0];
            end
            else if (cmd.emit_flush)
            begin
                pend_reg <= '0;
                pcnt_reg <= '0;
            end
            if (cmd.emit_byte || cmd.emit_err || cmd.emit_flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.build)
        begin
            win_reg <= win_build;
        end
        else if (cmd.emit_byte)
        begin
            win_reg <= win_reg << 8;
        end
        if (cmd.emit_byte)
        begin
            out_byte_reg   <= win_reg[WIN_W-1 -: 8];
            out_status_reg <= ST_DATA;
            out_last_reg   <= (cnt_reg >> 3) == CNT_W'(1);
        end
        else if (cmd.emit_err)
        begin
            out_byte_reg   <= '0;
            out_status_reg <= ST_ERROR;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.emit_flush)
        begin
            out_byte_reg   <= (pcnt_reg == '0) ? 8'd0 : {pend_reg, 1'b0};
            out_status_reg <= (pcnt_reg == '0) ? ST_END : ST_DATA;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

@@ rtl/prefix_code_bit_packer.sv @@
`timescale 1ns / 1ps
// load: the table write happens at the accept edge; unused opcode: accepted, no result
// encode: n output bytes (0 to 4) through table read, window build, one byte per
// cycle out of the window shift register while the output slot is free, then pending update
// flush: a single result from the pending bits; unmapped symbol: a single error result
// a result waiting on m_axis_tready stalls the sequence; async active-low reset clears
// control, pending bits and the length valid flags; code store undefined until loaded

module prefix_code_bit_packer
    import pcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // symbol, code_bits, code_length, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_byte
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    pcbp_cmd_t  cmd;
    pcbp_stat_t stat;

    pcbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .opcode   (s_axis_tuser),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    pcbp_datapath #(
        .LEN_LIMIT (LEN_LIMIT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .symbol      (s_axis_tdata[7:0]),
        .code_bits   (s_axis_tdata[39:8]),
        .code_length (s_axis_tdata[45:40]),
        .out_ready   (m_axis_tready),
        .stat        (stat),
        .out_valid   (m_axis_tvalid),
        .out_byte    (m_axis_tdata),
        .out_status  (m_axis_tuser),
        .out_last    (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_byte, cmd.emit_err, cmd.emit_flush}))
        else $error("more than one result issued in a cycle");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_byte || cmd.emit_err || cmd.emit_flush) |-> stat.slot_free)
        else $error("result issued while output register is occupied");

    a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_FLUSH) |=> !s_axis_tready)
        else $error("input accepted while a flush is in progress");
`endif

endmodule

@@ tb/tb_prefix_code_bit_packer.sv @@
`timescale 1ns / 1ps

module tb_prefix_code_bit_packer;
    import pcbp_pkg::*;

    localparam int MAX_LEN        = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  opcode;
        logic [7:0]  symbol;
        logic [31:0] code_bits;
        logic [5:0]  code_length;
    } packer_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } packed_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = OP_LOAD;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    packer_item_t   stim_items[$];
    packer_item_t   drive_item;
    packed_result_t packed_results[$];
    packed_result_t got_result;
    packed_result_t want_result;

    // predictor state
    logic [31:0] code_mem [256];
    logic [5:0]  len_mem  [256];
    logic [6:0]  pend_bits = '0;
    int          pend_cnt = 0;

    // generator bookkeeping
    logic [7:0]  written_syms[$];
    logic [7:0]  mapped_syms[$];

    int  send_gap = 0;
    int  stall_cnt = 0;
    int  long_holds_wanted = 0;
    int  long_holds_served = 0;
    int  quiet_cycles = 0;
    int  mismatches = 0;
    bit  calm = 1'b0;

    prefix_code_bit_packer #(
        .MAX_CODE_LEN(MAX_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
    begin
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    end
    endtask

    task automatic add_result(input logic [7:0] b, input logic [1:0] st, input logic lst);
        packed_result_t r;
    begin
        r.out_byte = b;
        r.status   = st;
        r.last     = lst;
        packed_results.push_back(r);
    end
    endtask

    task automatic predict_packing(input logic [1:0] op, input logic [7:0] sym,
                                   input logic [31:0] code, input logic [5:0] len);
        logic [7:0] shifted;
        int         nbits;
        int         total_bytes;
        int         produced;
    begin
        produced = 0;
        case (op)
            OP_LOAD:
            begin
                code_mem[sym] = code;
                len_mem[sym]  = (len > MAX_LEN) ? 6'(MAX_LEN) : len;
            end
            OP_ENCODE:
            begin
                nbits = int'(len_mem[sym]);
                if (nbits == 0)
                    add_result(8'h00, ST_ERROR, 1'b1);
                else
                begin
                    total_bytes = (pend_cnt + nbits) / 8;
                    for (int i = nbits; i > 0; i--)
                    begin
                        shifted = {pend_bits, code_mem[sym][i-1]};
                        pend_cnt++;
                        if (pend_cnt == 8)
                        begin
                            produced++;
                            add_result(shifted, ST_DATA, produced == total_bytes);
                            pend_bits = '0;
                            pend_cnt  = 0;
                        end
                        else
                            pend_bits = shifted[6:0];
                    end
                end
            end
            OP_FLUSH:
            begin
                if (pend_cnt != 0)
                begin
                    shifted = {1'b0, pend_bits} << (8 - pend_cnt);
                    add_result(shifted, ST_DATA, 1'b1);
                end
                else
                    add_result(8'h00, ST_END, 1'b1);
                pend_bits = '0;
                pend_cnt  = 0;
            end
            default:
            begin
            end
        endcase
    end
    endtask

    task automatic push_item(input logic [1:0] op, input logic [7:0] sym,
                             input logic [31:0] code, input logic [5:0] len);
        packer_item_t it;
    begin
        it.opcode      = op;
        it.symbol      = sym;
        it.code_bits   = code;
        it.code_length = len;
        stim_items.push_back(it);
        if (op == OP_LOAD)
        begin
            written_syms.push_back(sym);
            if (len != 0)
                mapped_syms.push_back(sym);
        end
    end
    endtask

    task automatic random_load(input logic [7:0] sym);
        int         pick;
        logic [5:0] len;
    begin
        pick = $urandom_range(0, 15);
        if (pick == 0)
            len = 6'd0;
        else if (pick == 1)
            len = 6'($urandom_range(33, 63));
        else if (pick < 5)
            len = 6'($urandom_range(13, 32));
        else
            len = 6'($urandom_range(1, 12));
        push_item(OP_LOAD, sym, $urandom, len);
    end
    endtask

    task automatic random_mix(input int count);
        int pick;
    begin
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55 && mapped_syms.size() > 0)
                push_item(OP_ENCODE,
                          mapped_syms[$urandom_range(0, mapped_syms.size() - 1)],
                          $urandom, 6'($urandom));
            else if (pick < 70)
                random_load(8'($urandom_range(0, 255)));
            else if (pick < 84)
                push_item(OP_FLUSH, 8'($urandom_range(0, 255)), $urandom, 6'($urandom));
            else if (pick < 94 && written_syms.size() > 0)
                push_item(OP_ENCODE,
                          written_syms[$urandom_range(0, written_syms.size() - 1)],
                          $urandom, 6'($urandom));
            else
                push_item(OP_UNUSED, 8'($urandom_range(0, 255)), $urandom, 6'($urandom));
        end
    end
    endtask

    task automatic wait_idle(input int extra);
    begin
        while (stim_items.size() != 0 || s_axis_tvalid || packed_results.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= OP_LOAD;
            send_gap      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (send_gap > 0)
            begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (stim_items.size() > 0)
            begin
                drive_item = stim_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= drive_item.opcode;
                s_axis_tdata  <= {2'b00, drive_item.code_length, drive_item.code_bits,
                                  drive_item.symbol};
                if (!calm && $urandom_range(0, 3) == 0)
                    send_gap <= $urandom_range(1, 18);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_cnt     <= 0;
        end
        else if (long_holds_served != long_holds_wanted)
        begin
            long_holds_served <= long_holds_wanted;
            stall_cnt         <= LONG_HOLD;
            m_axis_tready     <= 1'b0;
        end
        else if (stall_cnt > 0)
        begin
            stall_cnt     <= stall_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_cnt     <= $urandom_range(0, 17);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // predict on accepted items, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_packing(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8],
                                s_axis_tdata[45:40]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_result.out_byte = m_axis_tdata;
                got_result.status   = m_axis_tuser;
                got_result.last     = m_axis_tlast;
                if (packed_results.size() == 0)
                    report_mismatch("unexpected item", int'(got_result), 0);
                else
                begin
                    want_result = packed_results.pop_front();
                    if (got_result.out_byte != want_result.out_byte)
                        report_mismatch("out_byte", int'(got_result.out_byte),
                                        int'(want_result.out_byte));
                    if (got_result.status != want_result.status)
                        report_mismatch("status", int'(got_result.status),
                                        int'(want_result.status));
                    if (got_result.last != want_result.last)
                        report_mismatch("last", int'(got_result.last),
                                        int'(want_result.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // unmapped symbol, empty flush, unused opcode
        push_item(OP_LOAD, 8'h33, 32'hFFFF_FFFF, 6'd0);
        push_item(OP_ENCODE, 8'h33, 32'h0, 6'd0);
        push_item(OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        push_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        // longest code, shortest code, overlong length, bits above length ignored
        push_item(OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
        push_item(OP_LOAD, 8'h00, 32'h0000_0000, 6'd1);
        push_item(OP_LOAD, 8'h5A, 32'h8000_0001, 6'd63);
        push_item(OP_LOAD, 8'hA5, 32'hAAAA_AAAD, 6'd3);
        push_item(OP_LOAD, 8'h01, 32'h1234_5655, 6'd7);
        push_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
        push_item(OP_ENCODE, 8'h00, 32'h0, 6'd0);
        push_item(OP_ENCODE, 8'hA5, 32'h0, 6'd0);
        push_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
        push_item(OP_ENCODE, 8'h5A, 32'h0, 6'd0);
        // seven bits pending, then a full-length code: four bytes out
        push_item(OP_ENCODE, 8'h01, 32'h0, 6'd0);
        push_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
        push_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
        // unmapping keeps pending bits intact
        push_item(OP_ENCODE, 8'hA5, 32'h0, 6'd0);
        push_item(OP_LOAD, 8'hA5, 32'h0, 6'd0);
        push_item(OP_ENCODE, 8'hA5, 32'h0, 6'd0);
        push_item(OP_UNUSED, 8'h00, 32'h0, 6'd0);
        push_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
        push_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);

        repeat (24) random_load(8'($urandom_range(0, 255)));
        random_mix(60);
        wait_idle(12);

        random_mix(60);
        long_holds_wanted++;
        while (stim_items.size() != 0)
            @(negedge clk);

        calm = 1'b1;
        random_mix(30);
        wait_idle(20);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
